>>> src/amc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types and codes for the alpha matte compositor: pixel byte type,
// byte order codes, register indexes and the sideband carried with a pixel.
// ----------------------------------------------------------------------------
package amc_pkg;

  typedef logic [7:0] pix_byte_t;

  // Byte order codes, as written to the pixel order register
  localparam logic [1:0] ORDER_RGBA = 2'd0;
  localparam logic [1:0] ORDER_BGRA = 2'd1;
  localparam logic [1:0] ORDER_ABGR = 2'd2;
  localparam logic [1:0] ORDER_ARGB = 2'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_ORDER = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PREMULT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MATTE_RED  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MATTE_GRN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MATTE_BLU  = 3'd4;

  localparam pix_byte_t BYTE_FULL  = 8'hFF;
  localparam logic [15:0] ROUND_HALF = 16'd128;

  // Per-pixel sideband that rides along the pipeline
  typedef struct packed {
    logic [1:0] order;
    logic       line_end;
    logic       frame_end;
  } side_t;

endpackage

>>> src/amc_byte_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_byte_mul
// Two-stage exact rounded byte product: i = x*y + 128; (i + (i >> 8)) >> 8.
// Stage one registers the raw product, stage two the rounded byte.
// ----------------------------------------------------------------------------
module amc_byte_mul (
  input  logic              clk_i,
  input  amc_pkg::pix_byte_t x_i,
  input  amc_pkg::pix_byte_t y_i,
  output amc_pkg::pix_byte_t prod_o
);
  import amc_pkg::*;

  logic [15:0] prod_d, prod_q;
  logic [15:0] bias;
  logic [15:0] fold;
  pix_byte_t   res_d, res_q;

  // Raw 8x8 product
  assign prod_d = 16'(x_i) * 16'(y_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Round: add half, fold the high byte back in, keep the high byte
  assign bias  = prod_q + ROUND_HALF;
  assign fold  = bias + {8'd0, bias[15:8]};
  assign res_d = fold[15:8];

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign prod_o = res_q;

endmodule

>>> src/alpha_matte_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_matte_compositor
// Composites a 4-byte pixel over a solid matte color held in registers.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge with start_i high; busy_o is always
// low, so one pixel per clock is sustained indefinitely. Each pixel comes
// out on out_valid_o, in order, after the registered steps of channel
// select and multiply, rounding, and sum and repack, and must be taken in
// that cycle since results cannot be held off. Color channels are first
// scaled by alpha unless the premultiplied flag is set, then become
// mul(matte, 255 - alpha) + color, wrapping at 8 bits; output alpha is 255.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; writes to
// unused indexes are dropped. Change them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module alpha_matte_compositor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [amc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  // pixel input
  input  logic                          start_i,
  output logic                          busy_o,
  input  amc_pkg::pix_byte_t            in_byte0_i,
  input  amc_pkg::pix_byte_t            in_byte1_i,
  input  amc_pkg::pix_byte_t            in_byte2_i,
  input  amc_pkg::pix_byte_t            in_byte3_i,
  input  logic                          line_end_i,
  input  logic                          frame_end_i,
  // pixel output
  output logic                          out_valid_o,
  output amc_pkg::pix_byte_t            out_byte0_o,
  output amc_pkg::pix_byte_t            out_byte1_o,
  output amc_pkg::pix_byte_t            out_byte2_o,
  output amc_pkg::pix_byte_t            out_byte3_o,
  output logic                          out_line_end_o,
  output logic                          out_frame_end_o
);
  import amc_pkg::*;

  // Configuration registers
  logic [1:0] pixel_order_q;
  logic       premult_q;
  pix_byte_t  matte_red_q, matte_grn_q, matte_blu_q;

  // Pipeline control and sideband
  logic  v1_q, v2_q, v3_q;
  side_t side0, side1_q, side2_q;

  // Stage A signals
  pix_byte_t red, grn, blu, alpha;
  pix_byte_t scale, inv_alpha;
  pix_byte_t col_in   [3];
  pix_byte_t matte_in [3];
  pix_byte_t col_out  [3];
  pix_byte_t shade_out[3];

  // Stage C signals
  pix_byte_t sum[3];
  pix_byte_t ob0_d, ob1_d, ob2_d, ob3_d;
  pix_byte_t ob0_q, ob1_q, ob2_q, ob3_q;
  logic      ole_q, ofe_q;

  // No back pressure: a pixel can enter on every clock
  assign busy_o = 1'b0;

  // Write configuration registers; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_order_q <= ORDER_RGBA;
      premult_q     <= 1'b0;
      matte_red_q   <= '0;
      matte_grn_q   <= '0;
      matte_blu_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PIXEL_ORDER: pixel_order_q <= cfg_wdata_i[1:0];
        REG_PREMULT:     premult_q     <= cfg_wdata_i[0];
        REG_MATTE_RED:   matte_red_q   <= cfg_wdata_i;
        REG_MATTE_GRN:   matte_grn_q   <= cfg_wdata_i;
        REG_MATTE_BLU:   matte_blu_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage A: pick channels out of the pixel by byte order
  always_comb begin
    unique case (pixel_order_q)
      ORDER_RGBA: begin
        red = in_byte0_i; grn = in_byte1_i; blu = in_byte2_i; alpha = in_byte3_i;
      end
      ORDER_BGRA: begin
        red = in_byte2_i; grn = in_byte1_i; blu = in_byte0_i; alpha = in_byte3_i;
      end
      ORDER_ABGR: begin
        red = in_byte3_i; grn = in_byte2_i; blu = in_byte1_i; alpha = in_byte0_i;
      end
      ORDER_ARGB: begin
        red = in_byte1_i; grn = in_byte2_i; blu = in_byte3_i; alpha = in_byte0_i;
      end
      default: begin
        red = in_byte0_i; grn = in_byte1_i; blu = in_byte2_i; alpha = in_byte3_i;
      end
    endcase
  end

  // Premultiplied input scales by full alpha, which the rounded product
  // returns unchanged
  assign scale     = premult_q ? BYTE_FULL : alpha;
  assign inv_alpha = BYTE_FULL - alpha;

  assign col_in[0]   = red;
  assign col_in[1]   = grn;
  assign col_in[2]   = blu;
  assign matte_in[0] = matte_red_q;
  assign matte_in[1] = matte_grn_q;
  assign matte_in[2] = matte_blu_q;

  // Stages A and B: color times alpha, matte times inverse alpha
  for (genvar c = 0; c < 3; c++) begin : g_chan
    amc_byte_mul u_col_mul (
      .clk_i  (clk_i),
      .x_i    (col_in[c]),
      .y_i    (scale),
      .prod_o (col_out[c])
    );
    amc_byte_mul u_matte_mul (
      .clk_i  (clk_i),
      .x_i    (matte_in[c]),
      .y_i    (inv_alpha),
      .prod_o (shade_out[c])
    );
  end

  assign side0 = '{order: pixel_order_q, line_end: line_end_i, frame_end: frame_end_i};

  // Advance valid bits with the multiplier stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Carry sideband alongside the products
  always_ff @(posedge clk_i) begin
    side1_q <= side0;
    side2_q <= side1_q;
  end

  // Stage C: add matte share to color, wrapping at 8 bits
  for (genvar c = 0; c < 3; c++) begin : g_sum
    assign sum[c] = shade_out[c] + col_out[c];
  end

  // Put channels back at their byte offsets, alpha forced to full
  always_comb begin
    unique case (side2_q.order)
      ORDER_RGBA: begin
        ob0_d = sum[0]; ob1_d = sum[1]; ob2_d = sum[2]; ob3_d = BYTE_FULL;
      end
      ORDER_BGRA: begin
        ob0_d = sum[2]; ob1_d = sum[1]; ob2_d = sum[0]; ob3_d = BYTE_FULL;
      end
      ORDER_ABGR: begin
        ob0_d = BYTE_FULL; ob1_d = sum[2]; ob2_d = sum[1]; ob3_d = sum[0];
      end
      ORDER_ARGB: begin
        ob0_d = BYTE_FULL; ob1_d = sum[0]; ob2_d = sum[1]; ob3_d = sum[2];
      end
      default: begin
        ob0_d = sum[0]; ob1_d = sum[1]; ob2_d = sum[2]; ob3_d = BYTE_FULL;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    ob0_q <= ob0_d;
    ob1_q <= ob1_d;
    ob2_q <= ob2_d;
    ob3_q <= ob3_d;
    ole_q <= side2_q.line_end;
    ofe_q <= side2_q.frame_end;
  end

  assign out_valid_o     = v3_q;
  assign out_byte0_o     = ob0_q;
  assign out_byte1_o     = ob1_q;
  assign out_byte2_o     = ob2_q;
  assign out_byte3_o     = ob3_q;
  assign out_line_end_o  = ole_q;
  assign out_frame_end_o = ofe_q;

endmodule

>>> sim/alpha_matte_compositor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_matte_compositor_test
// Self-checking bench for the alpha matte compositor. A directed table covers
// reset values, matte and alpha extremes, every byte order, premultiplied
// wrap-around and marker copy; random phases then reprogram the registers
// and stream pixels with random gaps. Every output pixel is compared field by
// field against an in-bench compositing model.
// ----------------------------------------------------------------------------
module alpha_matte_compositor_test;
  import amc_pkg::*;

  // Directed stimulus row: register setting, pixel {byte3..byte0}, markers,
  // and an optional hand-computed result
  typedef struct packed {
    logic [1:0]  order;
    logic        premult;
    logic [23:0] matte;   // {red, green, blue}
    logic [31:0] pix;
    logic        le;
    logic        fe;
    logic        typed;
    logic [31:0] want;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] pix;
    logic        le;
    logic        fe;
  } pixel_out_t;

  localparam int RandomPixels = 750;
  localparam int ShowLimit    = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]         cfg_wdata_i;
  logic               start_i;
  logic               busy_o;
  pix_byte_t          in_byte0_i, in_byte1_i, in_byte2_i, in_byte3_i;
  logic               line_end_i, frame_end_i;
  logic               out_valid_o;
  pix_byte_t          out_byte0_o, out_byte1_o, out_byte2_o, out_byte3_o;
  logic               out_line_end_o, out_frame_end_o;

  // Register copy used by the compositing model
  logic [1:0] order_q;
  logic       premult_q;
  pix_byte_t  matte_q [3];

  pixel_out_t blended_q [$];
  stim_row_t  dir_rows [$];
  int         errors;

  alpha_matte_compositor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_byte0_i     (in_byte0_i),
    .in_byte1_i     (in_byte1_i),
    .in_byte2_i     (in_byte2_i),
    .in_byte3_i     (in_byte3_i),
    .line_end_i     (line_end_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_byte0_o    (out_byte0_o),
    .out_byte1_o    (out_byte1_o),
    .out_byte2_o    (out_byte2_o),
    .out_byte3_o    (out_byte3_o),
    .out_line_end_o (out_line_end_o),
    .out_frame_end_o(out_frame_end_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Exact rounded byte product
  function automatic pix_byte_t byte_scale(pix_byte_t x, pix_byte_t y);
    logic [16:0] acc;
    acc = x * y + 17'd128;
    return 8'((acc + (acc >> 8)) >> 8);
  endfunction

  // Composite one pixel {byte3..byte0} over the matte with the current setting
  function automatic logic [31:0] blend_pixel(logic [31:0] pix);
    logic [3:0][1:0] off;  // byte offsets of red, green, blue, alpha
    logic [3:0][7:0] src;
    logic [3:0][7:0] res;
    pix_byte_t       alpha;
    pix_byte_t       col;
    src = pix;
    case (order_q)
      ORDER_RGBA: off = {2'd3, 2'd2, 2'd1, 2'd0};
      ORDER_BGRA: off = {2'd3, 2'd0, 2'd1, 2'd2};
      ORDER_ABGR: off = {2'd0, 2'd1, 2'd2, 2'd3};
      default:    off = {2'd0, 2'd3, 2'd2, 2'd1};
    endcase
    alpha = src[off[3]];
    res = '0;
    for (int c = 0; c < 3; c++) begin
      col = src[off[c]];
      if (!premult_q) begin
        col = byte_scale(col, alpha);
      end
      res[off[c]] = byte_scale(matte_q[c], BYTE_FULL - alpha) + col;
    end
    res[off[3]] = BYTE_FULL;
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] order, logic premult, logic [23:0] matte,
                                       logic [31:0] pix, logic le, logic fe,
                                       logic typed, logic [31:0] want);
    stim_row_t r;
    r = '{order, premult, matte, pix, le, fe, typed, want};
    return r;
  endfunction

  function automatic pix_byte_t rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return pix_byte_t'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= ShowLimit) begin
      $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
  endtask

  // Check each output transfer against the oldest expected pixel
  always @(posedge clk_i) begin : check_out
    pixel_out_t      want;
    logic [3:0][7:0] got;
    if (rst_ni && out_valid_o) begin
      got = {out_byte3_o, out_byte2_o, out_byte1_o, out_byte0_o};
      if (blended_q.size() == 0) begin
        note_mismatch("unexpected output pixel", got, '0);
      end else begin
        want = blended_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want.pix[8*k +: 8]) begin
            note_mismatch($sformatf("out_byte%0d", k), 32'(got[k]),
                          32'(want.pix[8*k +: 8]));
          end
        end
        if (out_line_end_o !== want.le) begin
          note_mismatch("out_line_end", 32'(out_line_end_o), 32'(want.le));
        end
        if (out_frame_end_o !== want.fe) begin
          note_mismatch("out_frame_end", 32'(out_frame_end_o), 32'(want.fe));
        end
      end
    end
  end

  // Drive one pixel and hold it until the transfer; queue its expected result
  task automatic send_pixel(input logic [31:0] pix, input logic le, input logic fe,
                            input logic typed, input logic [31:0] want);
    start_i     <= 1'b1;
    in_byte0_i  <= pix[7:0];
    in_byte1_i  <= pix[15:8];
    in_byte2_i  <= pix[23:16];
    in_byte3_i  <= pix[31:24];
    line_end_i  <= le;
    frame_end_i <= fe;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    blended_q.push_back(pixel_out_t'{typed ? want : blend_pixel(pix), le, fe});
  endtask

  // Drop start for a random gap: mostly none or short, a few long
  task automatic idle_gap(input logic dense);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (dense || r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(4, 30);
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every pixel in flight to come out
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (blended_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_PIXEL_ORDER: order_q    = data[1:0];
      REG_PREMULT:     premult_q  = data[0];
      REG_MATTE_RED:   matte_q[0] = data;
      REG_MATTE_GRN:   matte_q[1] = data;
      REG_MATTE_BLU:   matte_q[2] = data;
      default: ;
    endcase
  endtask

  // Write all registers, optionally hitting the unused indexes too
  task automatic program_regs(input logic [7:0] order, input logic [7:0] premult,
                              input logic [23:0] matte, input logic unused);
    write_reg(REG_PIXEL_ORDER, order);
    write_reg(REG_PREMULT, premult);
    write_reg(REG_MATTE_RED, matte[23:16]);
    write_reg(REG_MATTE_GRN, matte[15:8]);
    write_reg(REG_MATTE_BLU, matte[7:0]);
    if (unused) begin
      for (int k = int'(REG_MATTE_BLU) + 1; k < 2 ** CfgIdxW; k++) begin
        write_reg(CfgIdxW'(k), 8'($urandom_range(0, 255)));
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t   row;
    logic [31:0] pix;
    logic [23:0] matte;
    logic        dense;
    int          sent;
    int          n;
    int          phase;

    errors      = 0;
    order_q     = ORDER_RGBA;
    premult_q   = 1'b0;
    matte_q     = '{8'h00, 8'h00, 8'h00};
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_PIXEL_ORDER;
    cfg_wdata_i <= 8'h00;
    start_i     <= 1'b0;
    in_byte0_i  <= 8'h00;
    in_byte1_i  <= 8'h00;
    in_byte2_i  <= 8'h00;
    in_byte3_i  <= 8'h00;
    line_end_i  <= 1'b0;
    frame_end_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; pixels and results are {byte3, byte2, byte1, byte0}
    // Reset setting: RGBA, not premultiplied, black matte
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h000000, 32'h00000000, 0, 0, 1, 32'hFF000000));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h000000, 32'hFFFFFFFF, 1, 0, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h000000, 32'h00563412, 0, 1, 1, 32'hFF000000));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h000000, 32'hFF563412, 1, 1, 1, 32'hFF563412));
    // White matte shows through fully transparent pixels
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'hFFFFFF, 32'h00000000, 0, 0, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'hFFFFFF, 32'h80808080, 0, 0, 0, '0));
    // Premultiplied color above alpha wraps the sum
    dir_rows.push_back(mk_row(ORDER_RGBA, 1, 24'hFFFFFF, 32'h00FFFFFF, 0, 0, 1, 32'hFFFEFEFE));
    dir_rows.push_back(mk_row(ORDER_RGBA, 1, 24'hFFFFFF, 32'hFF000000, 0, 0, 1, 32'hFF000000));
    // Output alpha is forced opaque whatever the input alpha
    dir_rows.push_back(mk_row(ORDER_RGBA, 1, 24'h000000, 32'h00C0B0A0, 1, 0, 1, 32'hFFC0B0A0));
    // Alpha lands in the right byte for every order
    dir_rows.push_back(mk_row(ORDER_BGRA, 0, 24'h000000, 32'h00345612, 0, 0, 1, 32'hFF000000));
    dir_rows.push_back(mk_row(ORDER_ABGR, 0, 24'h000000, 32'h12345600, 0, 0, 1, 32'h000000FF));
    dir_rows.push_back(mk_row(ORDER_ARGB, 0, 24'h000000, 32'h12345600, 0, 1, 1, 32'h000000FF));
    // Matte channels placed per order
    dir_rows.push_back(mk_row(ORDER_BGRA, 0, 24'hFF00FF, 32'h00000000, 0, 0, 1, 32'hFFFF00FF));
    dir_rows.push_back(mk_row(ORDER_ARGB, 1, 24'h00FF00, 32'h00000000, 0, 0, 1, 32'h00FF00FF));
    // Partial alpha in every order
    dir_rows.push_back(mk_row(ORDER_BGRA, 0, 24'h204060, 32'h80112233, 0, 0, 0, '0));
    dir_rows.push_back(mk_row(ORDER_ABGR, 0, 24'h204060, 32'h33221180, 1, 0, 0, '0));
    dir_rows.push_back(mk_row(ORDER_ARGB, 0, 24'h204060, 32'h44332280, 0, 1, 0, '0));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h7F8001, 32'h7F01FE80, 0, 0, 0, '0));
    dir_rows.push_back(mk_row(ORDER_RGBA, 0, 24'h7F8001, 32'h017F80FE, 0, 0, 0, '0));
    dir_rows.push_back(mk_row(ORDER_ABGR, 1, 24'hC03010, 32'h90A0B040, 1, 1, 0, '0));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.order != order_q || row.premult != premult_q ||
          row.matte != {matte_q[0], matte_q[1], matte_q[2]}) begin
        drain_pipe();
        program_regs(8'(row.order), 8'(row.premult), row.matte, 1'b0);
      end
      send_pixel(row.pix, row.le, row.fe, row.typed, row.want);
      idle_gap(1'b0);
    end

    // Random phases: reprogram while idle, then stream pixels
    sent  = 0;
    phase = 0;
    while (sent < RandomPixels) begin
      drain_pipe();
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0:       matte[23 - 8*c -: 8] = 8'h00;
          1:       matte[23 - 8*c -: 8] = 8'hFF;
          default: matte[23 - 8*c -: 8] = 8'($urandom_range(0, 255));
        endcase
      end
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), matte,
                   phase == 0 || $urandom_range(0, 2) == 0);
      dense = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      for (int k = 0; k < n && sent < RandomPixels; k++) begin
        pix = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        send_pixel(pix, $urandom_range(0, 7) == 0, $urandom_range(0, 31) == 0, 1'b0, '0);
        sent++;
        idle_gap(dense);
      end
      phase++;
    end

    // Let the pipeline empty, then settle
    start_i <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
